// File: rtl/core/hvsf_pkg.sv
// Shared types, constants and register indexes of the voxel surface fill block.
package hvsf_pkg;

    localparam int unsigned CoordWidth = 64;
    localparam int unsigned VarWidth   = 16;
    localparam int unsigned CodeWidth  = 32;
    localparam int unsigned RemWidth   = VarWidth + 1;
    localparam int unsigned ModCells   = CoordWidth;
    localparam int unsigned IdxWidth   = 3;

    localparam logic [63:0] MIX_MUL1  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL2  = 64'h94d049bb133111eb;
    localparam logic [63:0] SIGN_FLIP = 64'h8000000000000000;

    localparam logic [IdxWidth-1:0] REG_WORLD_SEED   = 3'd0;
    localparam logic [IdxWidth-1:0] REG_REGION_HASH  = 3'd1;
    localparam logic [IdxWidth-1:0] REG_BASE_SURFACE = 3'd2;
    localparam logic [IdxWidth-1:0] REG_VARIATION    = 3'd3;
    localparam logic [IdxWidth-1:0] REG_TERRAIN_CODE = 3'd4;
    localparam logic [IdxWidth-1:0] REG_AIR_CODE     = 3'd5;

    typedef struct packed {
        logic signed [CoordWidth-1:0] block_x;
        logic signed [CoordWidth-1:0] block_y;
        logic signed [CoordWidth-1:0] block_z;
    } hvsf_in_t;

    typedef struct packed {
        logic signed [CoordWidth-1:0] surf_height;
        logic                         solid;
        logic [CodeWidth-1:0]         cell_code;
    } hvsf_out_t;

    // One word travelling down the modulo chain
    typedef struct packed {
        logic                  valid;
        logic [CoordWidth-1:0] block_y;
        logic [RemWidth-1:0]   rem;
        logic [CoordWidth-1:0] dividend;
    } hvsf_mod_t;

    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] r;
        r = 64'(a) * 64'(b);
        return r;
    endfunction

endpackage

// File: rtl/core/hashed_voxel_surface_fill.sv
// Top level of the hashed voxel surface fill block.
// Takes one block coordinate per clock and returns its column surface height, solid flag
// and cell code after four parallel finalizers (block x, block z, world seed and region hash),
// the final mix, the chain of restoring-division cells, one per hash bit (one dividend bit
// per cell), that reduces the hash modulo 2*variation+1, the saturating add and
// the output register. Throughput is one word per clock; the whole pipeline
// holds while the output word waits. Configuration writes take effect at once; the user
// must make them only while no word is in flight, which the block itself does not enforce.
module hashed_voxel_surface_fill (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  hvsf_pkg::hvsf_in_t                     s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output hvsf_pkg::hvsf_out_t                    m_data,
    input  logic                                   cfg_wr_en,
    input  logic [hvsf_pkg::IdxWidth-1:0]          cfg_index,
    input  logic [63:0]                            cfg_wdata
);

    localparam int unsigned MixStages = 6;

    logic [63:0] seed_reg, region_reg, base_reg;
    logic [hvsf_pkg::VarWidth-1:0]  var_reg;
    logic [hvsf_pkg::CodeWidth-1:0] terrain_reg, air_reg;

    logic en;
    logic [MixStages-1:0] mix_valid_reg;
    logic [hvsf_pkg::CoordWidth-1:0] mix_y_reg [MixStages];

    logic [63:0] fx, fz, fs, fr, h, hmix;
    logic [hvsf_pkg::RemWidth-1:0] divisor;

    hvsf_pkg::hvsf_mod_t chain [hvsf_pkg::ModCells+1];

    logic                 sat_valid_reg;
    logic signed [63:0]   sat_y_reg, sat_surf_reg;
    logic signed [17:0]   offset;
    logic signed [64:0]   sum;
    logic signed [63:0]   surf_next;

    logic      out_valid_reg;
    hvsf_pkg::hvsf_out_t out_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg    <= '0;
            region_reg  <= '0;
            base_reg    <= '0;
            var_reg     <= '0;
            terrain_reg <= '0;
            air_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hvsf_pkg::REG_WORLD_SEED:   seed_reg    <= cfg_wdata;
                hvsf_pkg::REG_REGION_HASH:  region_reg  <= cfg_wdata;
                hvsf_pkg::REG_BASE_SURFACE: base_reg    <= cfg_wdata;
                hvsf_pkg::REG_VARIATION:    var_reg     <= cfg_wdata[hvsf_pkg::VarWidth-1:0];
                hvsf_pkg::REG_TERRAIN_CODE: terrain_reg <= cfg_wdata[hvsf_pkg::CodeWidth-1:0];
                hvsf_pkg::REG_AIR_CODE:     air_reg     <= cfg_wdata[hvsf_pkg::CodeWidth-1:0];
                default: ;
            endcase
        end
    end

    // advance everything unless the output word is stuck
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    hvsf_fmix u_mix_x (.aclk(aclk), .en(en),
        .din(s_data.block_x ^ hvsf_pkg::SIGN_FLIP), .dout(fx));
    hvsf_fmix u_mix_z (.aclk(aclk), .en(en),
        .din({s_data.block_z[62:0] ^ hvsf_pkg::SIGN_FLIP[62:0], 1'b0}), .dout(fz));
    hvsf_fmix u_mix_s (.aclk(aclk), .en(en), .din(seed_reg), .dout(fs));
    hvsf_fmix u_mix_r (.aclk(aclk), .en(en), .din(region_reg), .dout(fr));

    assign h = fx ^ fz ^ fs ^ fr;

    hvsf_fmix u_mix_h (.aclk(aclk), .en(en), .din(h), .dout(hmix));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mix_valid_reg <= '0;
        end else if (en) begin
            mix_valid_reg <= {mix_valid_reg[MixStages-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mix_y_reg[0] <= s_data.block_y;
            for (int i = 1; i < MixStages; i++) begin
                mix_y_reg[i] <= mix_y_reg[i-1];
            end
        end
    end

    assign divisor  = {var_reg, 1'b1};
    assign chain[0] = '{valid: mix_valid_reg[MixStages-1], block_y: mix_y_reg[MixStages-1],
                        rem: '0, dividend: hmix};

    for (genvar g = 0; g < hvsf_pkg::ModCells; g++) begin : g_mod
        hvsf_mod_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .divisor (divisor),
            .cell_in (chain[g]),
            .cell_out(chain[g+1])
        );
    end

    // recenter and saturate
    assign offset = $signed({1'b0, chain[hvsf_pkg::ModCells].rem})
                  - $signed({2'b0, var_reg});
    assign sum    = {base_reg[63], base_reg} + 65'(offset);

    always_comb begin
        if (sum[64] != sum[63]) begin
            surf_next = sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else begin
            surf_next = sum[63:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_valid_reg <= 1'b0;
        end else if (en) begin
            sat_valid_reg <= chain[hvsf_pkg::ModCells].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sat_y_reg    <= chain[hvsf_pkg::ModCells].block_y;
            sat_surf_reg <= surf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= sat_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.surf_height <= sat_surf_reg;
            out_reg.solid       <= (sat_y_reg <= sat_surf_reg);
            out_reg.cell_code   <= (sat_y_reg <= sat_surf_reg) ? terrain_reg : air_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_stall_holds_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (sat_valid_reg && !en) |=> (sat_valid_reg && $stable(sat_surf_reg)))
        else $error("saturation stage changed while stalled");

    a_solid_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (sat_valid_reg && en) |=> (m_valid &&
            m_data.solid == ($past(sat_y_reg) <= m_data.surf_height)))
        else $error("solid flag disagrees with surface height");

    a_surface_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        (sat_valid_reg && en) |=> (m_data.surf_height == $past(sat_surf_reg)))
        else $error("surface height lost at output register");

endmodule

// File: rtl/core/hvsf_fmix.sv
// Three-stage splitmix64 finalizer built from 32x32 partial products.
module hvsf_fmix (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] din,
    output logic [63:0] dout
);

    logic [63:0] p0_reg, p1_reg, p2_reg;
    logic [63:0] q0_reg, q1_reg, q2_reg;
    logic [63:0] out_reg;
    logic [63:0] t, m1, u, m2;
    logic [31:0] p_cross, q_cross;

    assign t       = din ^ (din >> 30);
    assign p_cross = p1_reg[31:0] + p2_reg[31:0];
    assign m1      = p0_reg + {p_cross, 32'b0};
    assign u       = m1 ^ (m1 >> 27);
    assign q_cross = q1_reg[31:0] + q2_reg[31:0];
    assign m2      = q0_reg + {q_cross, 32'b0};

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg  <= hvsf_pkg::mul32(t[31:0], hvsf_pkg::MIX_MUL1[31:0]);
            p1_reg  <= hvsf_pkg::mul32(t[31:0], hvsf_pkg::MIX_MUL1[63:32]);
            p2_reg  <= hvsf_pkg::mul32(t[63:32], hvsf_pkg::MIX_MUL1[31:0]);
            q0_reg  <= hvsf_pkg::mul32(u[31:0], hvsf_pkg::MIX_MUL2[31:0]);
            q1_reg  <= hvsf_pkg::mul32(u[31:0], hvsf_pkg::MIX_MUL2[63:32]);
            q2_reg  <= hvsf_pkg::mul32(u[63:32], hvsf_pkg::MIX_MUL2[31:0]);
            out_reg <= m2 ^ (m2 >> 31);
        end
    end

    assign dout = out_reg;

endmodule

// File: rtl/core/hvsf_mod_cell.sv
// One restoring-division step of the modulo chain: one dividend bit per cell.
module hvsf_mod_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic [hvsf_pkg::RemWidth-1:0]       divisor,
    input  hvsf_pkg::hvsf_mod_t                 cell_in,
    output hvsf_pkg::hvsf_mod_t                 cell_out
);

    logic                           valid_reg;
    logic [hvsf_pkg::CoordWidth-1:0] y_reg, dividend_reg;
    logic [hvsf_pkg::RemWidth-1:0]  rem_reg, rem_next;
    logic [hvsf_pkg::RemWidth:0]    trial;

    // shift in the next dividend bit, subtract when it fits
    assign trial = {cell_in.rem, cell_in.dividend[hvsf_pkg::CoordWidth-1]};

    always_comb begin
        if (trial >= {1'b0, divisor}) begin
            rem_next = hvsf_pkg::RemWidth'(trial - {1'b0, divisor});
        end else begin
            rem_next = trial[hvsf_pkg::RemWidth-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg        <= cell_in.block_y;
            rem_reg      <= rem_next;
            dividend_reg <= {cell_in.dividend[hvsf_pkg::CoordWidth-2:0], 1'b0};
        end
    end

    assign cell_out = '{valid: valid_reg, block_y: y_reg, rem: rem_reg,
                        dividend: dividend_reg};

endmodule

// File: tb/tb.sv
// Self-checking testbench of the hashed voxel surface fill block.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned PipeDepth = 72;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    hvsf_pkg::hvsf_in_t   s_data;
    logic                 m_valid;
    logic                 m_ready;
    hvsf_pkg::hvsf_out_t  m_data;
    logic                 cfg_wr_en;
    logic [hvsf_pkg::IdxWidth-1:0] cfg_index;
    logic [63:0]          cfg_wdata;

    // predictor copy of the registers
    logic [63:0] seed_q, region_q, base_q;
    logic [15:0] var_q;
    logic [31:0] terrain_q, air_q;

    hvsf_pkg::hvsf_out_t surface_q[$];
    int          err_cnt;
    int          send_idle_pct;
    int          recv_stall_pct;

    hashed_voxel_surface_fill i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [63:0] finalize(input logic [63:0] v);
        logic [63:0] t;
        t = v ^ (v >> 30);
        t = t * hvsf_pkg::MIX_MUL1;
        t = t ^ (t >> 27);
        t = t * hvsf_pkg::MIX_MUL2;
        t = t ^ (t >> 31);
        return t;
    endfunction

    function automatic hvsf_pkg::hvsf_out_t predict_voxel(input hvsf_pkg::hvsf_in_t w);
        hvsf_pkg::hvsf_out_t r;
        logic [63:0] h, rng;
        logic signed [65:0] sum;
        logic signed [63:0] surf;
        if (var_q == 16'd0) begin
            surf = base_q;
        end else begin
            h = finalize(seed_q) ^ finalize(w.block_x ^ hvsf_pkg::SIGN_FLIP)
                ^ finalize((w.block_z ^ hvsf_pkg::SIGN_FLIP) << 1) ^ finalize(region_q);
            rng = 64'(var_q) * 2 + 1;
            sum = $signed({{2{base_q[63]}}, base_q})
                + $signed(66'(finalize(h) % rng)) - $signed(66'(var_q));
            if (sum > 66'sh0_7fff_ffff_ffff_ffff)
                surf = 64'sh7fff_ffff_ffff_ffff;
            else if (sum < -66'sh0_8000_0000_0000_0000)
                surf = 64'sh8000_0000_0000_0000;
            else
                surf = sum[63:0];
        end
        r.surf_height = surf;
        r.solid       = ($signed(w.block_y) <= surf);
        r.cell_code   = r.solid ? terrain_q : air_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    task automatic write_reg(input logic [hvsf_pkg::IdxWidth-1:0] idx,
                             input logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            hvsf_pkg::REG_WORLD_SEED:   seed_q    = val;
            hvsf_pkg::REG_REGION_HASH:  region_q  = val;
            hvsf_pkg::REG_BASE_SURFACE: base_q    = val;
            hvsf_pkg::REG_VARIATION:    var_q     = val[15:0];
            hvsf_pkg::REG_TERRAIN_CODE: terrain_q = val[31:0];
            hvsf_pkg::REG_AIR_CODE:     air_q     = val[31:0];
            default: ;
        endcase
    endtask

    task automatic send_voxel(input logic [63:0] x, input logic [63:0] y,
                              input logic [63:0] z);
        hvsf_pkg::hvsf_in_t w;
        w.block_x = x;
        w.block_y = y;
        w.block_z = z;
        // drop valid only while idling
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        surface_q.insert(surface_q.size(), predict_voxel(w));
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (surface_q.size() != 0) @(posedge aclk);
        repeat (PipeDepth + 8) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64;
        return {$urandom, $urandom};
    endfunction

    // coordinate biased toward extremes and small values
    function automatic logic [63:0] rand_coord;
        case ($urandom_range(5))
            0: return 64'h7fff_ffff_ffff_ffff - 64'($urandom_range(3));
            1: return 64'h8000_0000_0000_0000 + 64'($urandom_range(3));
            2: return 64'($signed($urandom_range(200)) - 100);
            default: return rand64();
        endcase
    endfunction

    task automatic set_config(input logic [63:0] seed, input logic [63:0] region,
                              input logic [63:0] base, input logic [63:0] vari);
        write_reg(hvsf_pkg::REG_WORLD_SEED, seed);
        write_reg(hvsf_pkg::REG_REGION_HASH, region);
        write_reg(hvsf_pkg::REG_BASE_SURFACE, base);
        write_reg(hvsf_pkg::REG_VARIATION, vari);
        write_reg(hvsf_pkg::REG_TERRAIN_CODE, rand64());
        write_reg(hvsf_pkg::REG_AIR_CODE, rand64());
    endtask

    task automatic test_reset_defaults;
        send_voxel(64'd0, 64'd0, 64'd0);
        send_voxel(64'd5, 64'd1, 64'd7);
        send_voxel(64'd5, 64'hffff_ffff_ffff_ffff, 64'd7);
        drain();
    endtask

    task automatic test_directed;
        set_config(64'd0, 64'd0, 64'd0, 64'd0);
        send_voxel(64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000);
        send_voxel(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
        drain();
        // saturation at the top and bottom of the height range
        set_config(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                   64'h7fff_ffff_ffff_fff0, 64'hffff);
        for (int i = 0; i < 5; i++)
            send_voxel(rand_coord(), 64'h7fff_ffff_ffff_ffff - 64'(i), rand_coord());
        drain();
        set_config(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                   64'h8000_0000_0000_0010, 64'h1_ffff);
        for (int i = 0; i < 5; i++)
            send_voxel(rand_coord(), 64'h8000_0000_0000_0000 + 64'(i), rand_coord());
        drain();
        // write the unknown indexes; set_config below then rewrites every register anyway
        write_reg(3'd6, rand64());
        write_reg(3'd7, rand64());
        set_config(64'd1, 64'd2, 64'd0, 64'd1);
        for (int i = 0; i < 6; i++)
            send_voxel(rand_coord(), 64'($signed(i) - 3), rand_coord());
        drain();
    endtask

    task automatic test_random(input int n_items);
        logic [63:0] base, vari;
        for (int p = 0; p < 5; p++) begin
            base = (p == 0) ? rand64() : 64'($signed($urandom_range(2000)) - 1000);
            case (p)
                0: vari = 64'hffff;
                1: vari = 64'd0;
                2: vari = 64'($urandom_range(3));
                default: vari = 64'($urandom_range(65535));
            endcase
            set_config(rand64(), rand64(), base, vari);
            for (int i = 0; i < n_items / 5; i++) begin
                if ($urandom_range(3) == 0)
                    send_voxel(rand_coord(), rand_coord(), rand_coord());
                else
                    send_voxel(rand_coord(),
                               base + 64'($signed($urandom_range(2 * 65536 + 40)) - 65556),
                               rand_coord());
            end
            drain();
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        hvsf_pkg::hvsf_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (surface_q.size() == 0) begin
                report_mismatch("unexpected word", m_data.surf_height, 64'd0);
            end else begin
                want = surface_q.pop_front();
                if (m_data.surf_height !== want.surf_height)
                    report_mismatch("surf_height", m_data.surf_height, want.surf_height);
                if (m_data.solid !== want.solid)
                    report_mismatch("solid", 64'(m_data.solid), 64'(want.solid));
                if (m_data.cell_code !== want.cell_code)
                    report_mismatch("cell_code", 64'(m_data.cell_code), 64'(want.cell_code));
            end
        end
    end

    // receiver stall
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        err_cnt        = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        seed_q = '0; region_q = '0; base_q = '0;
        var_q = '0; terrain_q = '0; air_q = '0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_random(100);
        send_idle_pct = 62;
        test_random(100);
        send_idle_pct  = 0;
        recv_stall_pct = 62;
        test_random(100);
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        test_random(125);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/core/hvsf_pkg.sv
rtl/core/hvsf_fmix.sv
rtl/core/hvsf_mod_cell.sv
rtl/core/hashed_voxel_surface_fill.sv
tb/tb.sv
